// ----- hdl/postfix_expression_evaluator_assert.svh -----
// Assertion macros for the postfix evaluator.
// Both expect a signal named clk in the scope of use; PEE_ASSERT_CLK also needs arst_n.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Checked only outside reset.
`define PEE_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define PEE_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pee_pkg.sv -----
`default_nettype none

package pee_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	// quotient bits of (|a| << 16) / |b|
	localparam int Q_BITS      = DATA_W + FRAC_W;
	localparam int STEP_W      = $clog2(Q_BITS);

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	localparam logic [2:0] STAT_OK               = 3'd0;
	localparam logic [2:0] STAT_OPERAND_LAST     = 3'd1;
	localparam logic [2:0] STAT_OPERATOR_EARLY   = 3'd2;
	localparam logic [2:0] STAT_EXCESS_OPERATORS = 3'd3;
	localparam logic [2:0] STAT_ILLEGAL_CHAR     = 3'd4;
	localparam logic [2:0] STAT_EXCESS_OPERANDS  = 3'd5;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_cmd_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	// Integer value of a letter, already in Q16.16.
	function automatic logic [DATA_W-1:0] letter_q16(input logic [4:0] idx);
		logic [5:0] v;
		begin
			case (idx)
				5'd0:  v = 6'd20;
				5'd1:  v = 6'd30;
				5'd2:  v = 6'd4;
				5'd3:  v = 6'd12;
				5'd4:  v = 6'd41;
				5'd5:  v = 6'd2;
				5'd6:  v = 6'd6;
				5'd7:  v = 6'd15;
				5'd8:  v = 6'd21;
				5'd9:  v = 6'd27;
				5'd10: v = 6'd31;
				5'd11: v = 6'd38;
				5'd12: v = 6'd10;
				5'd13: v = 6'd5;
				5'd14: v = 6'd16;
				5'd15: v = 6'd45;
				5'd16: v = 6'd14;
				5'd17: v = 6'd1;
				5'd18: v = 6'd33;
				5'd19: v = 6'd9;
				5'd20: v = 6'd39;
				5'd21: v = 6'd32;
				5'd22: v = 6'd24;
				5'd23: v = 6'd28;
				5'd24: v = 6'd46;
				5'd25: v = 6'd50;
				default: v = 6'd0;
			endcase
			letter_q16 = {{(DATA_W - FRAC_W - 6){1'b0}}, v, {FRAC_W{1'b0}}};
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pee_if.sv -----
`default_nettype none

// Expression characters, one word per character.
interface pee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       end_of_expr;

	modport source (output valid, output symbol, output end_of_expr, input ready);
	modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

// One result word per expression.
interface pee_out_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  status;
	logic signed [31:0] answer;

	modport source (output valid, output status, output answer, input ready);
	modport sink   (input valid, input status, input answer, output ready);
endinterface

`default_nettype wire

// ----- hdl/pee_cell.sv -----
`default_nettype none

// One stack entry. Push takes the neighbor nearer the top, pop the one below.
module pee_cell (
	input  wire logic                      clk,
	input  wire pee_pkg::cell_cmd_t        cmd,
	input  wire logic [pee_pkg::DATA_W-1:0] left,
	input  wire logic [pee_pkg::DATA_W-1:0] right,
	output logic      [pee_pkg::DATA_W-1:0] value
);
	import pee_pkg::*;

	logic [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			value_q <= left;
		end else if (cmd.pop) begin
			value_q <= right;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

// ----- hdl/pee_alu.sv -----
`default_nettype none

// Q16.16 arithmetic unit. Add/sub register the result from idle,
// multiply uses a product register, divide one quotient bit per cycle.
module pee_alu (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pee_pkg::alu_req_t         req,
	input  wire logic [pee_pkg::DATA_W-1:0] lhs,
	input  wire logic [pee_pkg::DATA_W-1:0] rhs,
	output logic                           done,
	output logic      [pee_pkg::DATA_W-1:0] result
);
	import pee_pkg::*;

	typedef enum logic [1:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_DSAT
	} alu_state_t;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		mag32 = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
	endfunction

	// Sign a magnitude and clamp to 32 bits.
	function automatic logic [DATA_W-1:0] sat_mag(input logic [Q_BITS-1:0] mag,
	                                              input logic neg);
		logic big;
		begin
			big = |mag[Q_BITS-1:DATA_W-1];
			if (neg) begin
				sat_mag = big ? SAT_MIN : (~mag[DATA_W-1:0] + DATA_W'(1));
			end else begin
				sat_mag = big ? SAT_MAX : mag[DATA_W-1:0];
			end
		end
	endfunction

	alu_state_t          state_q;
	logic                done_q;
	logic [DATA_W-1:0]   result_q;
	logic                neg_q;
	logic [2*DATA_W-1:0] prod_s1;
	logic [Q_BITS-1:0]   num_q;
	logic [DATA_W-1:0]   den_q;
	logic [DATA_W-1:0]   rem_q;
	logic [STEP_W-1:0]   step_q;

	logic [DATA_W-1:0] mag_l, mag_r;
	logic              neg_in;
	logic [DATA_W:0]   sum, dif;
	logic [DATA_W-1:0] sum_sat, dif_sat, dz_val;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] trial;
	logic              fits;

	always_comb begin
		mag_l   = mag32(lhs);
		mag_r   = mag32(rhs);
		neg_in  = lhs[DATA_W-1] ^ rhs[DATA_W-1];
		sum     = {lhs[DATA_W-1], lhs} + {rhs[DATA_W-1], rhs};
		dif     = {lhs[DATA_W-1], lhs} - {rhs[DATA_W-1], rhs};
		sum_sat = (sum[DATA_W] != sum[DATA_W-1]) ? (sum[DATA_W] ? SAT_MIN : SAT_MAX)
		                                         : sum[DATA_W-1:0];
		dif_sat = (dif[DATA_W] != dif[DATA_W-1]) ? (dif[DATA_W] ? SAT_MIN : SAT_MAX)
		                                         : dif[DATA_W-1:0];
		// divide by zero follows the dividend's sign
		if (lhs == '0) begin
			dz_val = '0;
		end else begin
			dz_val = lhs[DATA_W-1] ? SAT_MIN : SAT_MAX;
		end
		shifted = {rem_q, num_q[Q_BITS-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		fits    = ~trial[DATA_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						neg_q <= neg_in;
						case (req.op)
							OP_ADD: begin
								result_q <= sum_sat;
								done_q   <= 1'b1;
							end
							OP_SUB: begin
								result_q <= dif_sat;
								done_q   <= 1'b1;
							end
							OP_MUL: begin
								prod_s1 <= {{DATA_W{1'b0}}, mag_l} * {{DATA_W{1'b0}}, mag_r};
								state_q <= A_MUL;
							end
							OP_DIV: begin
								if (rhs == '0) begin
									result_q <= dz_val;
									done_q   <= 1'b1;
								end else begin
									num_q   <= {mag_l, {FRAC_W{1'b0}}};
									den_q   <= mag_r;
									rem_q   <= '0;
									step_q  <= STEP_W'(Q_BITS - 1);
									state_q <= A_DIV;
								end
							end
							default: begin
								result_q <= '0;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				A_MUL: begin
					result_q <= sat_mag(prod_s1[2*DATA_W-1:FRAC_W], neg_q);
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				A_DIV: begin
					// restoring step: quotient bits shift in behind the numerator
					rem_q <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
					num_q <= {num_q[Q_BITS-2:0], fits};
					if (step_q == '0) begin
						state_q <= A_DSAT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				A_DSAT: begin
					result_q <= sat_mag(num_q, neg_q);
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- hdl/postfix_expression_evaluator.sv -----
// Postfix (RPN) evaluator in signed Q16.16. Feed one character per word on
// expr, end_of_expr set on the last one; one word comes out on result for
// each expression (status, and answer, which is zero unless status is ok).
// Letters a..z push a fixed table value, + - * / pop two entries and push the
// saturated result; the first error is latched and later characters are
// ignored until the end. Characters are taken only in the idle state: an
// operator that goes to the ALU holds off the next character until its
// result is back on the stack; after the last character of an expression
// the final state loads the result register once it is free. The ALU's
// restoring divider produces one of 48 quotient bits per cycle. The operand
// stack is a chain of 64 register cells that shift as a whole on push and
// pop; it needs no clearing pass after reset, a fill count tracks the valid
// depth. A push onto a full stack is dropped. The next expression may start
// while the previous result word still waits on result.
`default_nettype none

module postfix_expression_evaluator (
	input wire logic  clk,
	input wire logic  arst_n,
	pee_in_if.sink    expr,
	pee_out_if.source result
);
	import pee_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FINAL
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         pos_q;
	logic [2:0]         err_q;
	logic               last_q;
	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [DATA_W-1:0]  out_answer_q;

	// stack chain, entry 0 is the top
	logic [DATA_W-1:0] cell_val [STACK_DEPTH];
	cell_cmd_t         cell_cmd;
	logic [DATA_W-1:0] push_val;

	alu_req_t          alu_req;
	logic              alu_done;
	logic [DATA_W-1:0] alu_result;

	logic              in_acc, no_err, is_letter, is_op, op_go, out_free, fin_load;
	op_t               op_dec;
	logic [2:0]        fin_status;
	logic [DATA_W-1:0] fin_answer;

	always_comb begin
		in_acc    = expr.valid && expr.ready;
		no_err    = (err_q == STAT_OK);
		is_letter = (expr.symbol >= CH_LOWER_A) && (expr.symbol <= CH_LOWER_Z);
		is_op     = (expr.symbol == CH_PLUS) || (expr.symbol == CH_MINUS) ||
		            (expr.symbol == CH_STAR) || (expr.symbol == CH_SLASH);
		case (expr.symbol)
			CH_PLUS:  op_dec = OP_ADD;
			CH_MINUS: op_dec = OP_SUB;
			CH_STAR:  op_dec = OP_MUL;
			default:  op_dec = OP_DIV;
		endcase
		// operator with position and depth both fine goes to the ALU
		op_go = in_acc && no_err && is_op && (pos_q == 2'd2) &&
		        (count_q >= CNT_W'(2));

		push_val      = letter_q16(5'(expr.symbol - CH_LOWER_A));
		cell_cmd.push = in_acc && no_err && is_letter && !expr.end_of_expr &&
		                (count_q < CNT_W'(STACK_DEPTH));
		cell_cmd.pop  = (state_q == S_EXEC) && alu_done;

		alu_req.start = op_go;
		alu_req.op    = op_dec;

		out_free = !out_valid_q || result.ready;
		fin_load = (state_q == S_FINAL) && out_free;

		// closing pop: exactly one entry left is a good answer
		if (!no_err) begin
			fin_status = err_q;
			fin_answer = '0;
		end else if (count_q == CNT_W'(1)) begin
			fin_status = STAT_OK;
			fin_answer = cell_val[0];
		end else if (count_q == '0) begin
			fin_status = STAT_OK;
			fin_answer = '0;
		end else begin
			fin_status = STAT_EXCESS_OPERANDS;
			fin_answer = '0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			logic [DATA_W-1:0] left_in, right_in;
			if (gi == 0) begin : g_top
				assign left_in  = push_val;
				assign right_in = alu_result;
			end else if (gi == STACK_DEPTH - 1) begin : g_bottom
				assign left_in  = cell_val[gi-1];
				assign right_in = cell_val[gi];
			end else begin : g_mid
				assign left_in  = cell_val[gi-1];
				assign right_in = cell_val[gi+1];
			end
			pee_cell u_cell (
				.clk   (clk),
				.cmd   (cell_cmd),
				.left  (left_in),
				.right (right_in),
				.value (cell_val[gi])
			);
		end
	endgenerate

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (cell_val[1]),
		.rhs    (cell_val[0]),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			err_q       <= STAT_OK;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word may replace the one taken at this edge
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= expr.end_of_expr;
						if (no_err) begin
							if (is_letter) begin
								if (expr.end_of_expr) begin
									err_q <= STAT_OPERAND_LAST;
								end else if (cell_cmd.push) begin
									count_q <= count_q + CNT_W'(1);
								end
							end else if (is_op) begin
								// position is checked before depth
								if (pos_q != 2'd2) begin
									err_q <= STAT_OPERATOR_EARLY;
								end else if (count_q < CNT_W'(2)) begin
									err_q <= STAT_EXCESS_OPERATORS;
								end
							end else begin
								err_q <= STAT_ILLEGAL_CHAR;
							end
							if (pos_q != 2'd2) begin
								pos_q <= pos_q + 2'd1;
							end
						end
						if (op_go) begin
							state_q <= S_EXEC;
						end else if (expr.end_of_expr) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_EXEC: begin
					// cells pop and the top takes the ALU result in the same edge
					if (alu_done) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= last_q ? S_FINAL : S_IDLE;
					end
				end
				S_FINAL: begin
					if (fin_load) begin
						out_status_q <= fin_status;
						out_answer_q <= fin_answer;
						count_q      <= '0;
						pos_q        <= '0;
						err_q        <= STAT_OK;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign expr.ready    = (state_q == S_IDLE);
	assign result.valid  = out_valid_q;
	assign result.status = out_status_q;
	assign result.answer = $signed(out_answer_q);

endmodule

`default_nettype wire

// ----- hdl/pee_checker.sv -----
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module pee_sva_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [2:0]  result_status,
	input wire logic [31:0] result_answer
);
	import pee_pkg::*;

	`PEE_ASSERT_CLK(a_valid_holds, result_valid && !result_ready |=> result_valid, "result word dropped while stalled")
	`PEE_ASSERT_CLK(a_word_holds, result_valid && !result_ready |=> $stable(result_status) && $stable(result_answer), "stalled result word changed")
	`PEE_ASSERT_CLK(a_err_zero, result_valid && result_status != STAT_OK |-> result_answer == '0, "nonzero answer with error status")
	`PEE_ASSERT_CLK(a_status_range, result_valid |-> result_status <= STAT_EXCESS_OPERANDS, "status code out of range")
	`PEE_ASSERT_ANY(a_reset_empty, !arst_n |=> !result_valid, "result valid right after reset")

endmodule

bind postfix_expression_evaluator pee_sva_checker u_pee_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_status (result.status),
	.result_answer (result.answer)
);

`default_nettype wire
